/* sv/cost_adaptive_checkpoint_period_defines.svh */
// Assertion macros for the cost-adaptive checkpoint period block
`ifndef COST_ADAPTIVE_CHECKPOINT_PERIOD_DEFINES_SVH
`define COST_ADAPTIVE_CHECKPOINT_PERIOD_DEFINES_SVH
`ifndef SYNTH
`define CACP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CACP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CACP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CACP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/cacp_pkg.sv */
// Types and constants shared by the checkpoint period modules
package cacp_pkg;

    localparam int unsigned ID_W     = 6;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COST_W   = 33;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned PERIOD_W = 8;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned PROD_W   = COST_W + COEF_W;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned CMP_W    = COST_W + 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COEF_W-1:0] KEEP_COEF = 16'd26214;
    localparam logic [COEF_W-1:0] NEW_COEF  = 16'd39321;

    localparam logic [COUNT_W-1:0]  RECALC_EVENTS_RST = 16'd100;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST    = 8'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_RECALC_EVENTS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD    = 8'd1;

    typedef struct packed {
        logic [ID_W-1:0]   obj_index;
        logic [TIME_W-1:0] state_time;
        logic [TIME_W-1:0] coast_time;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]     result_object;
        logic                recalculated;
        logic [PERIOD_W-1:0] checkpoint_period;
    } t_out;

    typedef struct packed {
        logic [COUNT_W-1:0]  event_count;
        logic                step_negative;
        logic [COST_W-1:0]   old_cost;
        logic [COST_W-1:0]   filtered_cost;
        logic [PERIOD_W-1:0] period_store;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_FLT,
        ST_WB
    } t_state;

    typedef struct packed {
        logic busy;
        logic accept;
        logic mul_en;
        logic flt_en;
        logic wb_en;
        logic clr_en;
    } t_ctrl;

endpackage

/* sv/cacp_state_mem.sv */
// Per-object state memory, one write port and one registered read port
module cacp_state_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  cacp_pkg::t_entry      i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output cacp_pkg::t_entry      o_rd_data
);

    cacp_pkg::t_entry r_mem [DEPTH];
    cacp_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/cacp_ctrl.sv */
// Sequencer for the clearing sweep and the read-modify-write of one event
module cacp_ctrl #(
    parameter int NUM_OBJECTS = 64,
    parameter int AW          = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output cacp_pkg::t_ctrl     o_ctrl,
    output logic [AW-1:0]       o_clr_addr
);

    cacp_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             w_clr_last;

    assign w_clr_last = (r_clr_addr == AW'(NUM_OBJECTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            cacp_pkg::ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = cacp_pkg::ST_IDLE;
                end
            end
            cacp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = cacp_pkg::ST_MUL;
                end
            end
            cacp_pkg::ST_MUL: n_state = cacp_pkg::ST_FLT;
            cacp_pkg::ST_FLT: n_state = cacp_pkg::ST_WB;
            cacp_pkg::ST_WB:  n_state = cacp_pkg::ST_IDLE;
            default:          n_state = cacp_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.busy   = (r_state != cacp_pkg::ST_IDLE);
        o_ctrl.accept = (r_state == cacp_pkg::ST_IDLE) && i_start;
        o_ctrl.mul_en = (r_state == cacp_pkg::ST_MUL);
        o_ctrl.flt_en = (r_state == cacp_pkg::ST_FLT);
        o_ctrl.wb_en  = (r_state == cacp_pkg::ST_WB);
        o_ctrl.clr_en = (r_state == cacp_pkg::ST_CLEAR);
    end

    assign n_clr_addr = (r_state == cacp_pkg::ST_CLEAR) ? r_clr_addr + AW'(1) : r_clr_addr;
    assign o_clr_addr = r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cacp_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

endmodule

/* sv/cacp_update.sv */
// Cost filter and period stepping for one object entry
module cacp_update (
    input  logic                              i_clk,
    input  cacp_pkg::t_ctrl                   i_ctrl,
    input  cacp_pkg::t_entry                  i_entry,
    input  logic [cacp_pkg::COST_W-1:0]       i_cost,
    input  logic                              i_coast_zero,
    input  logic [cacp_pkg::COUNT_W-1:0]      i_recalc_events,
    input  logic [cacp_pkg::PERIOD_W-1:0]     i_max_period,
    output cacp_pkg::t_entry                  o_entry,
    output logic                              o_recalc,
    output logic [cacp_pkg::PERIOD_W-1:0]     o_period
);

    localparam int unsigned SUM_W = cacp_pkg::PROD_W + 1;
    localparam int unsigned P_W   = cacp_pkg::PERIOD_W + 2;

    logic [cacp_pkg::PROD_W-1:0] r_prod_keep, r_prod_new;
    logic [cacp_pkg::PROD_W-1:0] w_prod_keep, w_prod_new;
    logic [SUM_W-1:0]            w_sum;
    logic [cacp_pkg::COST_W-1:0] r_filt;
    logic [cacp_pkg::CMP_W-1:0]  w_old5, w_filt6, w_filt4;
    logic                        w_gt, w_lt, w_do_recalc;
    logic signed [P_W-1:0]       w_p;
    logic [cacp_pkg::PERIOD_W-1:0] w_p_clamped;
    logic                        w_step_neg;
    logic [cacp_pkg::COST_W-1:0] w_old_new;

    assign w_prod_keep = cacp_pkg::PROD_W'(i_entry.filtered_cost)
                       * cacp_pkg::PROD_W'(cacp_pkg::KEEP_COEF);
    assign w_prod_new  = cacp_pkg::PROD_W'(i_cost) * cacp_pkg::PROD_W'(cacp_pkg::NEW_COEF);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod_keep <= w_prod_keep;
            r_prod_new  <= w_prod_new;
        end
    end

    assign w_sum = SUM_W'(r_prod_keep) + SUM_W'(r_prod_new);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.flt_en) begin
            r_filt <= w_sum[cacp_pkg::FRAC_W +: cacp_pkg::COST_W];
        end
    end

    assign w_old5  = cacp_pkg::CMP_W'({i_entry.old_cost, 2'b00})
                   + cacp_pkg::CMP_W'(i_entry.old_cost);
    assign w_filt6 = cacp_pkg::CMP_W'({r_filt, 2'b00}) + cacp_pkg::CMP_W'({r_filt, 1'b0});
    assign w_filt4 = cacp_pkg::CMP_W'({r_filt, 2'b00});
    assign w_gt    = (w_old5 > w_filt6);
    assign w_lt    = (w_old5 < w_filt4);

    assign w_do_recalc = (i_entry.event_count >= i_recalc_events);

    always_comb begin
        w_p        = signed'(P_W'(i_entry.period_store));
        w_step_neg = i_entry.step_negative;
        w_old_new  = i_entry.old_cost;
        if (i_entry.old_cost != '0) begin
            if (w_gt) begin
                w_p       = w_step_neg ? w_p - P_W'(1) : w_p + P_W'(1);
                w_old_new = r_filt;
            end else if (w_lt) begin
                w_step_neg = ~w_step_neg;
                w_p        = w_step_neg ? w_p - P_W'(1) : w_p + P_W'(1);
                w_old_new  = r_filt;
            end
            if (i_coast_zero) begin
                w_step_neg = 1'b0;
                w_p        = w_p + P_W'(1);
                w_old_new  = r_filt;
            end
        end else begin
            w_p       = w_p + P_W'(1);
            w_old_new = r_filt;
        end
    end

    always_comb begin
        if (w_p < 0) begin
            w_p_clamped = '0;
        end else if (w_p > signed'(P_W'(i_max_period))) begin
            w_p_clamped = i_max_period;
        end else begin
            w_p_clamped = w_p[cacp_pkg::PERIOD_W-1:0];
        end
    end

    always_comb begin
        o_entry = i_entry;
        if (w_do_recalc) begin
            o_entry.event_count   = cacp_pkg::COUNT_W'(1);
            o_entry.step_negative = w_step_neg;
            o_entry.old_cost      = w_old_new;
            o_entry.filtered_cost = r_filt;
            o_entry.period_store  = w_p_clamped;
        end else begin
            o_entry.event_count   = i_entry.event_count + cacp_pkg::COUNT_W'(1);
        end
    end

    assign o_recalc = w_do_recalc;
    assign o_period = w_do_recalc ? w_p_clamped : i_entry.period_store;

endmodule

/* sv/cost_adaptive_checkpoint_period.sv */
// Top level of the cost-adaptive checkpoint period block
//
// Channel   Direction  Handshake                 Payload
// event     in         start, busy               i_item (cacp_pkg::t_in)
// result    out        o_done (one-cycle strobe) o_result (cacp_pkg::t_out)
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each accepted event passes through memory read, coefficient multiply, filter add,
// compare and write-back before the result strobe; the sequencer holds busy until
// write-back is done, so a new event is not accepted before the last is written back.
// After reset the state memory is cleared one entry a cycle, all NUM_OBJECTS entries,
// with busy high; o_cfg_ready is always high, write configuration only while idle.
// The result cannot be stalled.
`include "cost_adaptive_checkpoint_period_defines.svh"

module cost_adaptive_checkpoint_period #(
    parameter int NUM_OBJECTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cacp_pkg::t_in                       i_item,
    output logic                                o_done,
    output cacp_pkg::t_out                      o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cacp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cacp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

    cacp_pkg::t_ctrl                  w_ctrl;
    logic [AW-1:0]                    w_clr_addr;
    cacp_pkg::t_entry                 w_rd_entry, w_upd_entry, w_wr_data;
    logic                             w_wr_en;
    logic [AW-1:0]                    w_wr_addr, w_rd_addr;
    logic                             w_in_range;
    logic                             w_upd_recalc;
    logic [cacp_pkg::PERIOD_W-1:0]    w_upd_period;

    logic [cacp_pkg::COUNT_W-1:0]     r_recalc_events;
    logic [cacp_pkg::PERIOD_W-1:0]    r_max_period;
    logic [cacp_pkg::ID_W-1:0]        r_obj;
    logic [AW-1:0]                    r_addr;
    logic                             r_in_range;
    logic [cacp_pkg::COST_W-1:0]      r_cost;
    logic                             r_coast_zero;
    logic                             r_done;
    cacp_pkg::t_out                   r_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recalc_events <= cacp_pkg::RECALC_EVENTS_RST;
            r_max_period    <= cacp_pkg::MAX_PERIOD_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == cacp_pkg::CFG_RECALC_EVENTS) begin
                r_recalc_events <= i_cfg_data;
            end else if (i_cfg_index == cacp_pkg::CFG_MAX_PERIOD) begin
                r_max_period <= i_cfg_data[cacp_pkg::PERIOD_W-1:0];
            end
        end
    end

    cacp_ctrl #(
        .NUM_OBJECTS (NUM_OBJECTS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_ctrl     (w_ctrl),
        .o_clr_addr (w_clr_addr)
    );

    assign busy       = w_ctrl.busy;
    assign w_in_range = (32'(i_item.obj_index) < NUM_OBJECTS);
    assign w_rd_addr  = AW'(i_item.obj_index);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_obj        <= i_item.obj_index;
            r_addr       <= w_rd_addr;
            r_in_range   <= w_in_range;
            r_cost       <= cacp_pkg::COST_W'(i_item.state_time)
                          + cacp_pkg::COST_W'(i_item.coast_time);
            r_coast_zero <= (i_item.coast_time == '0);
        end
    end

    assign w_wr_en   = w_ctrl.clr_en || (w_ctrl.wb_en && r_in_range);
    assign w_wr_addr = w_ctrl.clr_en ? w_clr_addr : r_addr;
    assign w_wr_data = w_ctrl.clr_en ? '0 : w_upd_entry;

    cacp_state_mem #(
        .DEPTH (NUM_OBJECTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_ctrl.accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry)
    );

    cacp_update u_update (
        .i_clk           (i_clk),
        .i_ctrl          (w_ctrl),
        .i_entry         (w_rd_entry),
        .i_cost          (r_cost),
        .i_coast_zero    (r_coast_zero),
        .i_recalc_events (r_recalc_events),
        .i_max_period    (r_max_period),
        .o_entry         (w_upd_entry),
        .o_recalc        (w_upd_recalc),
        .o_period        (w_upd_period)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_ctrl.wb_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.wb_en) begin
            r_result.result_object     <= r_obj;
            r_result.recalculated      <= r_in_range && w_upd_recalc;
            r_result.checkpoint_period <= r_in_range ? w_upd_period : '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `CACP_ASSERT_IMP(a_done_latency, i_clk, i_rst_n, start && !busy, ##4 o_done, "no strobe 4 cycles after start")
    `CACP_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result strobe while busy")
    `CACP_ASSERT_IMP(a_period_clamped, i_clk, i_rst_n, o_done && o_result.recalculated, o_result.checkpoint_period <= r_max_period, "period above clamp")
    `CACP_ASSERT_IMP(a_clear_busy, i_clk, i_rst_n, w_ctrl.clr_en, busy && !w_ctrl.wb_en, "clear while idle or writing")
    `CACP_ASSERT_NXT(a_no_double_done, i_clk, i_rst_n, o_done, !o_done, "result strobe too long")

endmodule

/* sim/tb.sv */
// Testbench for cost_adaptive_checkpoint_period: directed and random save events, predicted per object
`timescale 1ns / 1ps

module tb;

    localparam int NUM_OBJ = 64;
    localparam logic [cacp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST =
        cacp_pkg::CFG_MAX_PERIOD + cacp_pkg::CFG_IDX_W'(1);
    localparam logic [cacp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;
    localparam longint unsigned FILTER_KEEP = 26214;
    localparam longint unsigned FILTER_NEW  = 39321;
    localparam longint unsigned COST_MASK   = 64'h1_FFFF_FFFF;

    class checkpoint_predictor;
        logic [cacp_pkg::COUNT_W-1:0]  recalc_events;
        logic [cacp_pkg::PERIOD_W-1:0] max_period;
        logic [cacp_pkg::COUNT_W-1:0]  event_count [NUM_OBJ];
        bit                            step_neg [NUM_OBJ];
        longint unsigned               old_cost [NUM_OBJ];
        longint unsigned               filt_cost [NUM_OBJ];
        logic [cacp_pkg::PERIOD_W-1:0] period [NUM_OBJ];
        cacp_pkg::t_out                expected_results [$];
        int                            mismatches;

        function new();
            recalc_events = cacp_pkg::RECALC_EVENTS_RST;
            max_period    = cacp_pkg::MAX_PERIOD_RST;
            mismatches    = 0;
            for (int i = 0; i < NUM_OBJ; i++) begin
                event_count[i] = '0;
                step_neg[i]    = 1'b0;
                old_cost[i]    = 0;
                filt_cost[i]   = 0;
                period[i]      = '0;
            end
        endfunction

        function void apply_reg(logic [cacp_pkg::CFG_IDX_W-1:0] idx,
                                logic [cacp_pkg::CFG_DATA_W-1:0] val);
            if (idx == cacp_pkg::CFG_RECALC_EVENTS) begin
                recalc_events = val[cacp_pkg::COUNT_W-1:0];
            end else if (idx == cacp_pkg::CFG_MAX_PERIOD) begin
                max_period = val[cacp_pkg::PERIOD_W-1:0];
            end
        endfunction

        function void recalc(int id, logic [cacp_pkg::TIME_W-1:0] st,
                             logic [cacp_pkg::TIME_W-1:0] ct);
            longint unsigned cost;
            longint unsigned filt;
            longint unsigned old;
            int p;
            cost = longint'(st) + longint'(ct);
            filt = ((FILTER_KEEP * filt_cost[id] + FILTER_NEW * cost) >> cacp_pkg::FRAC_W)
                 & COST_MASK;
            old  = old_cost[id];
            p    = int'(period[id]);
            filt_cost[id] = filt;
            if (old != 0) begin
                if (old * 5 > filt * 6) begin
                    p += step_neg[id] ? -1 : 1;
                    old_cost[id] = filt;
                end else if (old * 5 < filt * 4) begin
                    step_neg[id] = !step_neg[id];
                    p += step_neg[id] ? -1 : 1;
                    old_cost[id] = filt;
                end
                if (ct == '0) begin
                    step_neg[id] = 1'b0;
                    p += 1;
                    old_cost[id] = filt;
                end
            end else begin
                p += 1;
                old_cost[id] = filt;
            end
            if (p < 0) begin
                p = 0;
            end else if (p > int'(max_period)) begin
                p = int'(max_period);
            end
            period[id]      = p[cacp_pkg::PERIOD_W-1:0];
            event_count[id] = cacp_pkg::COUNT_W'(1);
        endfunction

        function void note_event(cacp_pkg::t_in ev);
            cacp_pkg::t_out res;
            int id;
            id = int'(ev.obj_index);
            res.result_object     = ev.obj_index;
            res.recalculated      = 1'b0;
            res.checkpoint_period = '0;
            if (id < NUM_OBJ) begin
                if (event_count[id] < recalc_events) begin
                    event_count[id] = event_count[id] + cacp_pkg::COUNT_W'(1);
                end else begin
                    recalc(id, ev.state_time, ev.coast_time);
                    res.recalculated = 1'b1;
                end
                res.checkpoint_period = period[id];
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(cacp_pkg::t_out got);
            cacp_pkg::t_out want;
            if (expected_results.size() == 0) begin
                $error("unexpected result for object %0d", got.result_object);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.result_object !== want.result_object) begin
                $error("result_object: expected %0d, got %0d",
                       want.result_object, got.result_object);
                mismatches++;
            end
            if (got.recalculated !== want.recalculated) begin
                $error("recalculated: expected %0d, got %0d",
                       want.recalculated, got.recalculated);
                mismatches++;
            end
            if (got.checkpoint_period !== want.checkpoint_period) begin
                $error("checkpoint_period: expected %0d, got %0d",
                       want.checkpoint_period, got.checkpoint_period);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    cacp_pkg::t_in                   i_item = '0;
    logic                            o_done;
    cacp_pkg::t_out                  o_result;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cacp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cacp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    checkpoint_predictor periods;
    bit burst = 1'b0;

    cost_adaptive_checkpoint_period #(.NUM_OBJECTS(NUM_OBJ)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            periods.check_result(o_result);
        end
    end

    task automatic send_event(input logic [cacp_pkg::ID_W-1:0] id,
                              input logic [cacp_pkg::TIME_W-1:0] st,
                              input logic [cacp_pkg::TIME_W-1:0] ct);
        cacp_pkg::t_in ev;
        int gap;
        ev.obj_index  = id;
        ev.state_time = st;
        ev.coast_time = ct;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= ev;
        do @(posedge i_clk); while (busy);
        periods.note_event(ev);
    endtask

    task automatic write_reg(input logic [cacp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cacp_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        periods.apply_reg(idx, val);
    endtask

    task automatic set_regs(input logic [cacp_pkg::CFG_DATA_W-1:0] recalc,
                            input logic [cacp_pkg::CFG_DATA_W-1:0] maxp);
        logic [cacp_pkg::CFG_IDX_W-1:0] junk;
        junk = cacp_pkg::CFG_IDX_W'($urandom_range(int'(CFG_UNUSED_FIRST),
                                                    int'(CFG_UNUSED_LAST)));
        write_reg(cacp_pkg::CFG_RECALC_EVENTS, recalc);
        write_reg(cacp_pkg::CFG_MAX_PERIOD, maxp);
        write_reg(junk, cacp_pkg::CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (periods.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [cacp_pkg::TIME_W-1:0] draw_time(
        input logic [cacp_pkg::TIME_W-1:0] base);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return cacp_pkg::TIME_W'($urandom);
            3: return cacp_pkg::TIME_W'($urandom) >> $urandom_range(0, 31);
            default: return base + cacp_pkg::TIME_W'($urandom_range(0,
                                int'(base >> 3) & 32'h7FFF_FFFF));
        endcase
    endfunction

    initial begin
        logic [cacp_pkg::CFG_DATA_W-1:0] recalc;
        logic [cacp_pkg::PERIOD_W-1:0]   maxv;
        logic [2:0]                      pool_hi;
        logic [cacp_pkg::TIME_W-1:0]     base;
        logic [cacp_pkg::ID_W-1:0]       id;
        periods = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every event recalculates, widest clamp
        set_regs('0, '1);
        send_event(0, '1, '1);
        send_event(0, '1, '1);
        send_event(0, '0, '0);
        send_event(0, '0, '0);
        send_event(63, '0, '1);
        send_event(63, '1, '0);
        send_event(63, 32'hAAAA_AAAA, 32'h5555_5555);
        send_event(63, 32'h5555_5555, 32'hAAAA_AAAA);
        repeat (6) send_event(2, 32'h0001_0000, '0);
        repeat (2) send_event(21, 32'h0001_0000, 32'h0001_0000);
        repeat (2) send_event(42, 32'h0001_0000, 32'h0001_0000);
        drain();

        // lowered clamp: stored period reported unchanged until recalculated
        set_regs('1, 16'd3);
        send_event(2, 32'h0001_0000, '0);
        drain();
        set_regs(16'd1, 16'hFF00);
        send_event(2, 32'h0001_0000, 32'h0000_8000);
        send_event(2, 32'h0001_0000, 32'h0000_8000);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 4))
                0: recalc = '0;
                1: recalc = 16'd1;
                2: recalc = 16'd2;
                3: recalc = cacp_pkg::CFG_DATA_W'($urandom_range(3, 8));
                default: recalc = cacp_pkg::RECALC_EVENTS_RST;
            endcase
            case ($urandom_range(0, 2))
                0: maxv = '0;
                1: maxv = '1;
                default: maxv = cacp_pkg::PERIOD_W'($urandom_range(1, 40));
            endcase
            set_regs(recalc, {8'($urandom), maxv});
            pool_hi = 3'($urandom);
            base    = cacp_pkg::TIME_W'($urandom) >> $urandom_range(0, 24);
            for (int n = 0; n < 125; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    burst = !burst;
                end
                if ($urandom_range(0, 3) == 0) begin
                    id = cacp_pkg::ID_W'($urandom);
                end else begin
                    id = {pool_hi, 3'($urandom)};
                end
                send_event(id, draw_time(base), draw_time(base));
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (periods.mismatches == 0 && periods.pending() == 0) begin
            $display("** cost_adaptive_checkpoint_period: PASSED **");
        end else begin
            $display("** cost_adaptive_checkpoint_period: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** cost_adaptive_checkpoint_period: FAILED **");
        $finish;
    end

endmodule
